### hdl/icrc_pkg.sv
package icrc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [7:0] MASK_BYTE = 8'hFF;

  // IPv4/UDP/BTH byte offsets: variant fields (folded as all ones), length bytes and limits
  localparam logic [15:0] OFF_TOS       = 16'd1;
  localparam logic [15:0] OFF_LEN_HI    = 16'd2;
  localparam logic [15:0] OFF_LEN_LO    = 16'd3;
  localparam logic [15:0] OFF_HDR_END   = 16'd4;
  localparam logic [15:0] OFF_TTL       = 16'd8;
  localparam logic [15:0] OFF_IPCSUM_HI = 16'd10;
  localparam logic [15:0] OFF_IPCSUM_LO = 16'd11;
  localparam logic [15:0] OFF_UDPCSUM_HI = 16'd26;
  localparam logic [15:0] OFF_UDPCSUM_LO = 16'd27;
  localparam logic [15:0] OFF_BTH_RESV  = 16'd32;
  localparam logic [15:0] OFF_MAX       = 16'hFFFF;

  localparam logic [15:0] MIN_TOTAL_LEN = 16'd8;
  localparam logic [15:0] TRAILER_LEN   = 16'd4;
  localparam logic [15:0] TINY_COVER    = 16'd4;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       fold;
    logic       last;
    logic       short_pkt;
  } icrc_entry_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  localparam logic [31:0] CRC_INIT =
    crc_fold(crc_fold(crc_fold(crc_fold(32'h0, MASK_BYTE), MASK_BYTE), MASK_BYTE), MASK_BYTE);

endpackage

### hdl/icrc_front.sv
module icrc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  q_full,
  output logic                  push,
  output icrc_pkg::icrc_entry_t push_entry
);

  logic [15:0] byte_offset;
  logic [15:0] ip_len;
  logic [15:0] total_cur;
  logic [15:0] limit;
  logic [16:0] next_count;
  logic        accept;
  logic        covered;
  logic        variant;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (byte_offset == icrc_pkg::OFF_LEN_HI) begin
      total_cur = {data_byte, 8'h00};
    end else if (byte_offset == icrc_pkg::OFF_LEN_LO) begin
      total_cur = {ip_len[15:8], data_byte};
    end else begin
      total_cur = ip_len;
    end
  end

  assign limit = (total_cur < icrc_pkg::MIN_TOTAL_LEN) ? icrc_pkg::TINY_COVER
                                                         : total_cur - icrc_pkg::TRAILER_LEN;

  assign covered = (byte_offset < icrc_pkg::OFF_HDR_END) || (byte_offset < limit);

  assign variant = (byte_offset == icrc_pkg::OFF_TOS) ||
                   (byte_offset == icrc_pkg::OFF_TTL) ||
                   (byte_offset == icrc_pkg::OFF_IPCSUM_HI) ||
                   (byte_offset == icrc_pkg::OFF_IPCSUM_LO) ||
                   (byte_offset == icrc_pkg::OFF_UDPCSUM_HI) ||
                   (byte_offset == icrc_pkg::OFF_UDPCSUM_LO) ||
                   (byte_offset == icrc_pkg::OFF_BTH_RESV);

  // covered bytes are contiguous from zero, so the count after this byte is offset+1
  assign next_count = {1'b0, byte_offset} + 17'd1;

  always_comb begin
    push_entry.data      = variant ? icrc_pkg::MASK_BYTE : data_byte;
    push_entry.fold      = covered;
    push_entry.last      = last_byte;
    push_entry.short_pkt = (byte_offset < icrc_pkg::OFF_LEN_LO) ||
                           (next_count < {1'b0, limit});
  end

  // drop bytes past the covered length unless they end the packet
  assign push = accept && (covered || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      ip_len      <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_offset <= '0;
        ip_len      <= '0;
      end else begin
        ip_len <= total_cur;
        if (byte_offset != icrc_pkg::OFF_MAX) begin
          byte_offset <= byte_offset + 16'd1;
        end
      end
    end
  end

endmodule

### hdl/icrc_fifo.sv
module icrc_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  icrc_pkg::icrc_entry_t               push_entry,
  input  logic                                pop,
  output logic                                q_valid,
  output icrc_pkg::icrc_entry_t               q_entry,
  output logic                                q_full,
  output logic [icrc_pkg::FIFO_CW-1:0]        count
);

  icrc_pkg::icrc_entry_t            slots [icrc_pkg::FIFO_DEPTH];
  logic [icrc_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [icrc_pkg::FIFO_AW-1:0]     rd_ptr;
  logic                             do_push;
  logic                             do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == icrc_pkg::FIFO_CW'(icrc_pkg::FIFO_DEPTH));
  assign q_entry = slots[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == icrc_pkg::FIFO_AW'(icrc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == icrc_pkg::FIFO_AW'(icrc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/icrc_back.sv
module icrc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  icrc_pkg::icrc_entry_t q_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           icrc_value,
  output logic                  short_packet
);

  logic [31:0] crc;
  logic [31:0] crc_next;
  logic        slot_free;

  assign slot_free = !out_valid || !out_stall;
  // hold a final byte until the result register can take it
  assign pop       = q_valid && (!q_entry.last || slot_free);
  assign crc_next  = q_entry.fold ? icrc_pkg::crc_fold(crc, q_entry.data) : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= icrc_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        crc <= q_entry.last ? icrc_pkg::CRC_INIT : crc_next;
      end
      if (pop && q_entry.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      icrc_value   <= ~crc_next;
      short_packet <= q_entry.short_pkt;
    end
  end

endmodule

### hdl/rocev2_invariant_crc.sv
// RoCEv2 invariant CRC: takes a packet one byte per request, starting at the
// first byte of an option-less IPv4 header, and on the byte marked last returns
// one request with the inverted CRC-32 over the IPv4 length less four bytes
// (variant fields folded as 0xFF) and a flag for packets that ended early.
// One byte is taken every cycle unless stalled. A front stage tracks the offset
// and length and masks variant bytes, a two-entry queue decouples it from the
// back stage that folds one queued byte per cycle into the CRC unless a final
// byte waits on a held result, and an output register holds the result. Input
// stalls only when the queue fills behind a held result.
module rocev2_invariant_crc (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] icrc_value,
  output logic        short_packet
);

  icrc_pkg::icrc_entry_t              push_entry;
  icrc_pkg::icrc_entry_t              q_entry;
  logic                               push;
  logic                               pop;
  logic                               q_valid;
  logic                               q_full;
  logic [icrc_pkg::FIFO_CW-1:0]       q_count;

  icrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  icrc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_full     (q_full),
    .count      (q_count)
  );

  icrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .icrc_value   (icrc_value),
    .short_packet (short_packet)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= icrc_pkg::FIFO_CW'(icrc_pkg::FIFO_DEPTH))
    else $error("queue count exceeds depth");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (q_count == '0) && !out_valid)
    else $error("queue or result not cleared by reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) && !out_valid |=> !out_valid)
    else $error("result appeared without a queued byte");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> q_count == icrc_pkg::FIFO_CW'(icrc_pkg::FIFO_DEPTH))
    else $error("input stalled while queue has room");
`endif

endmodule

### tb/rocev2_invariant_crc_tb.sv
module rocev2_invariant_crc_tb;

  localparam int NUM_BYTES  = 1200;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 20;

  typedef struct {
    logic [31:0] icrc;
    logic        short_pkt;
  } icrc_result_t;

  class icrc_scoreboard;
    logic [31:0]  crc_acc;
    logic [15:0]  next_off;
    logic [15:0]  fold_cnt;
    logic [15:0]  ip_len;
    icrc_result_t expected_icrc_q[$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function logic [31:0] crc_byte(logic [31:0] r, logic [7:0] b);
      logic [31:0] x;
      x = r ^ {24'h0, b};
      for (int i = 0; i < 8; i++)
        x = (x >> 1) ^ (icrc_pkg::CRC_POLY & {32{x[0]}});
      return x;
    endfunction

    function void restart();
      crc_acc = 32'h0;
      for (int i = 0; i < 4; i++)
        crc_acc = crc_byte(crc_acc, icrc_pkg::MASK_BYTE);
      next_off = '0;
      fold_cnt = '0;
      ip_len   = '0;
    endfunction

    function logic [15:0] cover_len();
      if (ip_len < icrc_pkg::MIN_TOTAL_LEN)
        return icrc_pkg::TINY_COVER;
      return ip_len - icrc_pkg::TRAILER_LEN;
    endfunction

    function bit is_variant(logic [15:0] off);
      return off == icrc_pkg::OFF_TOS || off == icrc_pkg::OFF_TTL ||
             off == icrc_pkg::OFF_IPCSUM_HI || off == icrc_pkg::OFF_IPCSUM_LO ||
             off == icrc_pkg::OFF_UDPCSUM_HI || off == icrc_pkg::OFF_UDPCSUM_LO ||
             off == icrc_pkg::OFF_BTH_RESV;
    endfunction

    function void note_byte(logic [7:0] d, logic last);
      logic [15:0]  off;
      icrc_result_t res;
      off = next_off;
      if (off == icrc_pkg::OFF_LEN_HI)
        ip_len = {d, 8'h00};
      else if (off == icrc_pkg::OFF_LEN_LO)
        ip_len[7:0] = d;
      if (off < icrc_pkg::OFF_HDR_END || off < cover_len()) begin
        crc_acc  = crc_byte(crc_acc, is_variant(off) ? icrc_pkg::MASK_BYTE : d);
        fold_cnt = fold_cnt + 16'd1;
      end
      if (next_off != icrc_pkg::OFF_MAX)
        next_off = next_off + 16'd1;
      if (last) begin
        res.icrc      = ~crc_acc;
        res.short_pkt = (off < icrc_pkg::OFF_LEN_LO) ? 1'b1 : (fold_cnt < cover_len());
        expected_icrc_q.push_back(res);
        restart();
      end
    endfunction

    function void check_icrc(logic [31:0] icrc, logic short_pkt);
      icrc_result_t exp_res;
      if (expected_icrc_q.size() == 0) begin
        $error("unexpected result: icrc_value=%h short_packet=%b", icrc, short_pkt);
        errors++;
        return;
      end
      exp_res = expected_icrc_q.pop_front();
      if (icrc !== exp_res.icrc) begin
        $error("icrc_value: expected %h, actual %h", exp_res.icrc, icrc);
        errors++;
      end
      if (short_pkt !== exp_res.short_pkt) begin
        $error("short_packet: expected %b, actual %b", exp_res.short_pkt, short_pkt);
        errors++;
      end
    endfunction

    function int pending();
      return expected_icrc_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] icrc_value;
  logic        short_packet;

  icrc_scoreboard sb = new();
  int bytes_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_phase_left = 0;
  int stall_kind = 0;

  rocev2_invariant_crc dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .icrc_value   (icrc_value),
    .short_packet (short_packet)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall)
        sb.note_byte(data_byte, last_byte);
      if (out_valid && !out_stall)
        sb.check_icrc(icrc_value, short_packet);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: phases of no stall, solid stall, toggling, random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        stall_phase_left = (stall_kind == 1) ? $urandom_range(1, 20) : $urandom_range(1, 60);
      end
      stall_phase_left = stall_phase_left - 1;
      case (stall_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'b1;
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Build a packet: IPv4 length field at offsets 2 and 3, 0x45 at offset 0 if sane, random elsewhere
  task automatic send_packet(input logic [15:0] len_field, input int nbytes, input bit sane);
    logic [7:0] d;
    for (int i = 0; i < nbytes; i++) begin
      d = 8'($urandom_range(0, 255));
      if (i == 0 && sane)
        d = 8'h45;
      else if (i == 2)
        d = len_field[15:8];
      else if (i == 3)
        d = len_field[7:0];
      send_byte(d, i == nbytes - 1);
    end
  endtask

  // Hold off the sender until every expected CRC has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int kind;
    int pkt_len;
    logic [15:0] len_field;
    bit paused;
    paused = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // one-byte packet, length never seen
    send_byte(8'hFF, 1'b1);
    // packet ends at the high length byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // tiny lengths: only the four leading bytes are folded, the rest is not
    send_packet(16'h0004, 6, 0);
    send_packet(16'h0008, 8, 1);
    // huge length, packet cut short
    send_packet(16'hFFFF, 5, 0);
    wait_drained();

    while (bytes_sent < NUM_BYTES) begin
      kind = $urandom_range(0, 9);
      len_field = 16'($urandom_range(28, 96));
      if ($urandom_range(0, 19) == 0)
        len_field = 16'($urandom_range(97, 300));
      pkt_len = int'(len_field);
      if (kind == 7)
        pkt_len = $urandom_range(1, len_field - 1);
      else if (kind == 8)
        pkt_len = int'(len_field) + $urandom_range(1, 8);
      if (kind == 9) begin
        len_field = 16'($urandom_range(0, 16'hFFFF));
        send_packet(len_field, $urandom_range(1, 40), 0);
      end else begin
        send_packet(len_field, pkt_len, 1);
      end
      if (!paused && bytes_sent >= NUM_BYTES / 2) begin
        wait_drained();
        paused = 1;
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
